// ----- rtl/core/gpat_pkg.sv -----
// Package: gait phase assist torque types, constants and phase encoding.
`timescale 1ns / 1ps

package gpat_pkg;

    localparam int ANGLE_W  = 16;
    localparam int TORQUE_W = 19;
    localparam int PHASE_W  = 3;
    localparam int CFG_IDX_W = 3;

    localparam logic signed [10:0] FILTER_GAIN = 11'sd655;
    localparam logic signed [20:0] TORQUE_MAX  = 21'sd196608;
    localparam logic signed [20:0] TORQUE_MIN  = -21'sd196608;

    typedef enum logic [6:0] {
        PH_LOAD     = 7'b0000001,
        PH_MID      = 7'b0000010,
        PH_TSTANCE  = 7'b0000100,
        PH_PRESWING = 7'b0001000,
        PH_ISWING   = 7'b0010000,
        PH_MSWING   = 7'b0100000,
        PH_TSWING   = 7'b1000000
    } t_phase;

    // phase numbers as reported on the result channel
    typedef enum logic [PHASE_W-1:0] {
        GAIT_LOADING   = 3'd0,
        GAIT_MIDSTANCE = 3'd1,
        GAIT_TSTANCE   = 3'd2,
        GAIT_PRESWING  = 3'd3,
        GAIT_ISWING    = 3'd4,
        GAIT_MSWING    = 3'd5,
        GAIT_TSWING    = 3'd6
    } t_gait_code;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIDSTANCE_THIGH = 3'd0,
        CFG_TERMINAL_THIGH  = 3'd1,
        CFG_SWING_KNEE      = 3'd2,
        CFG_MID_SWING_KNEE  = 3'd3,
        CFG_END_SWING_KNEE  = 3'd4,
        CFG_LOADING_TARGET  = 3'd5,
        CFG_PUSH_TARGET     = 3'd6,
        CFG_LIFT_TARGET     = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic signed [ANGLE_W-1:0]  midstance_thigh_limit;
        logic signed [ANGLE_W-1:0]  terminal_thigh_limit;
        logic signed [ANGLE_W-1:0]  swing_knee_limit;
        logic signed [ANGLE_W-1:0]  mid_swing_knee_limit;
        logic signed [ANGLE_W-1:0]  end_swing_knee_limit;
        logic signed [TORQUE_W-1:0] loading_target;
        logic signed [TORQUE_W-1:0] push_target;
        logic signed [TORQUE_W-1:0] lift_target;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        midstance_thigh_limit: 16'sd500,
        terminal_thigh_limit:  -16'sd300,
        swing_knee_limit:      16'sd1500,
        mid_swing_knee_limit:  16'sd4000,
        end_swing_knee_limit:  16'sd2000,
        loading_target:        19'sd32768,
        push_target:           19'sd98304,
        lift_target:           -19'sd65536
    };

    function automatic logic [PHASE_W-1:0] phase_code(input t_phase p);
        logic [PHASE_W-1:0] c;
        c = GAIT_LOADING;
        case (p)
            PH_LOAD:     c = GAIT_LOADING;
            PH_MID:      c = GAIT_MIDSTANCE;
            PH_TSTANCE:  c = GAIT_TSTANCE;
            PH_PRESWING: c = GAIT_PRESWING;
            PH_ISWING:   c = GAIT_ISWING;
            PH_MSWING:   c = GAIT_MSWING;
            PH_TSWING:   c = GAIT_TSWING;
            default:     c = GAIT_LOADING;
        endcase
        return c;
    endfunction

endpackage

// ----- rtl/core/gait_phase_assist_torque.sv -----
// Top level: gait phase assist torque, input register, step logic, result register.
// o_valid rises once the step result of an accepted transaction is registered.
// Throughput: one transaction per cycle unless i_ready stalls the result register.
// Input register and result register each hold one transaction; while a result
// waits, one more transaction enters the input register, then o_ready drops.
// Reset (i_rst_n, synchronous, active low): registers to defaults, phase to loading,
// torque to zero, both channels empty; no clearing pass.
`timescale 1ns / 1ps

module gait_phase_assist_torque
    import gpat_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic signed [ANGLE_W-1:0]  i_thigh_angle,
    input  logic signed [ANGLE_W-1:0]  i_knee_angle,
    input  logic                       i_foot_down,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [PHASE_W-1:0]         o_phase_now,
    output logic signed [TORQUE_W-1:0] o_drive_torque,
    output logic                       o_in_stance,
    input  logic                       i_cfg_we,
    input  logic [CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [TORQUE_W-1:0]        i_cfg_data
);

    t_cfg                       r_cfg;
    logic                       r_in_valid;
    logic signed [ANGLE_W-1:0]  r_thigh;
    logic signed [ANGLE_W-1:0]  r_knee;
    logic                       r_foot;
    t_phase                     r_phase;
    logic signed [TORQUE_W-1:0] r_torque;
    logic                       r_out_valid;
    logic [PHASE_W-1:0]         r_phase_now;
    logic signed [TORQUE_W-1:0] r_drive;
    logic                       r_stance;

    t_phase                     n_phase;
    logic signed [TORQUE_W-1:0] n_torque;
    logic [PHASE_W-1:0]         n_phase_code;
    logic                       n_stance;
    logic                       w_adv;

    assign w_adv   = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_MIDSTANCE_THIGH: r_cfg.midstance_thigh_limit <= i_cfg_data[ANGLE_W-1:0];
                CFG_TERMINAL_THIGH:  r_cfg.terminal_thigh_limit  <= i_cfg_data[ANGLE_W-1:0];
                CFG_SWING_KNEE:      r_cfg.swing_knee_limit      <= i_cfg_data[ANGLE_W-1:0];
                CFG_MID_SWING_KNEE:  r_cfg.mid_swing_knee_limit  <= i_cfg_data[ANGLE_W-1:0];
                CFG_END_SWING_KNEE:  r_cfg.end_swing_knee_limit  <= i_cfg_data[ANGLE_W-1:0];
                CFG_LOADING_TARGET:  r_cfg.loading_target        <= i_cfg_data;
                CFG_PUSH_TARGET:     r_cfg.push_target           <= i_cfg_data;
                CFG_LIFT_TARGET:     r_cfg.lift_target           <= i_cfg_data;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_thigh <= i_thigh_angle;
            r_knee  <= i_knee_angle;
            r_foot  <= i_foot_down;
        end
    end

    gpat_step u_step (
        .i_phase       (r_phase),
        .i_torque      (r_torque),
        .i_thigh_angle (r_thigh),
        .i_knee_angle  (r_knee),
        .i_foot_down   (r_foot),
        .i_cfg         (r_cfg),
        .o_phase       (n_phase),
        .o_torque      (n_torque),
        .o_phase_code  (n_phase_code),
        .o_in_stance   (n_stance)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_LOAD;
            r_torque    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_adv) begin
                r_phase  <= n_phase;
                r_torque <= n_torque;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_phase_now <= n_phase_code;
            r_drive     <= n_torque;
            r_stance    <= n_stance;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_phase_now    = r_phase_now;
    assign o_drive_torque = r_drive;
    assign o_in_stance    = r_stance;

`ifndef SYNTH
    a_phase_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $past(w_adv)) |->
            (r_phase == $past(r_phase)
             || r_phase == t_phase'({$past(r_phase[5:0]), $past(r_phase[6])})))
        else $error("gait phase skipped a step");

    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && !$past(w_adv)) |-> ($stable(r_phase) && $stable(r_torque)))
        else $error("state changed without a transaction");

    a_torque_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ($signed({{2{r_drive[TORQUE_W-1]}}, r_drive}) <= TORQUE_MAX
                         && $signed({{2{r_drive[TORQUE_W-1]}}, r_drive}) >= TORQUE_MIN))
        else $error("drive torque outside saturation limits");

    a_result_matches_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $past(w_adv)) |-> (r_drive == r_torque
                                               && r_phase_now == phase_code(r_phase)))
        else $error("result register out of step with state");
`endif

endmodule

// ----- rtl/core/gpat_step.sv -----
// Gait phase transition, target select and torque low-pass filter for one tick.
`timescale 1ns / 1ps

module gpat_step
    import gpat_pkg::*;
(
    input  t_phase                     i_phase,
    input  logic signed [TORQUE_W-1:0] i_torque,
    input  logic signed [ANGLE_W-1:0]  i_thigh_angle,
    input  logic signed [ANGLE_W-1:0]  i_knee_angle,
    input  logic                       i_foot_down,
    input  t_cfg                       i_cfg,
    output t_phase                     o_phase,
    output logic signed [TORQUE_W-1:0] o_torque,
    output logic [PHASE_W-1:0]         o_phase_code,
    output logic                       o_in_stance
);

    logic signed [TORQUE_W-1:0] w_target;
    logic signed [TORQUE_W:0]   w_diff;
    logic signed [30:0]         w_prod;
    logic signed [14:0]         w_delta;
    logic signed [20:0]         w_acc;

    always_comb begin
        o_phase = i_phase;
        unique case (i_phase)
            PH_LOAD: begin
                if (i_thigh_angle > i_cfg.midstance_thigh_limit && i_foot_down) begin
                    o_phase = PH_MID;
                end
            end
            PH_MID: begin
                if (i_thigh_angle < i_cfg.terminal_thigh_limit) begin
                    o_phase = PH_TSTANCE;
                end
            end
            PH_TSTANCE: begin
                if (!i_foot_down) begin
                    o_phase = PH_PRESWING;
                end
            end
            PH_PRESWING: begin
                if (i_knee_angle > i_cfg.swing_knee_limit) begin
                    o_phase = PH_ISWING;
                end
            end
            PH_ISWING: begin
                if (i_knee_angle > i_cfg.mid_swing_knee_limit) begin
                    o_phase = PH_MSWING;
                end
            end
            PH_MSWING: begin
                if (i_knee_angle < i_cfg.end_swing_knee_limit) begin
                    o_phase = PH_TSWING;
                end
            end
            PH_TSWING: begin
                if (i_foot_down) begin
                    o_phase = PH_LOAD;
                end
            end
            default: begin
                o_phase = PH_LOAD;
            end
        endcase
    end

    always_comb begin
        case (o_phase)
            PH_LOAD:     w_target = i_cfg.loading_target;
            PH_TSTANCE:  w_target = i_cfg.push_target;
            PH_PRESWING: w_target = i_cfg.lift_target;
            default:     w_target = '0;
        endcase
    end

    // floor((target - current) * 655 / 2^16) via arithmetic shift
    assign w_diff  = {w_target[TORQUE_W-1], w_target} - {i_torque[TORQUE_W-1], i_torque};
    assign w_prod  = w_diff * FILTER_GAIN;
    assign w_delta = w_prod[30:16];
    assign w_acc   = {{2{i_torque[TORQUE_W-1]}}, i_torque} + {{6{w_delta[14]}}, w_delta};

    always_comb begin
        if (w_acc > TORQUE_MAX) begin
            o_torque = TORQUE_MAX[TORQUE_W-1:0];
        end else if (w_acc < TORQUE_MIN) begin
            o_torque = TORQUE_MIN[TORQUE_W-1:0];
        end else begin
            o_torque = w_acc[TORQUE_W-1:0];
        end
    end

    assign o_phase_code = phase_code(o_phase);
    assign o_in_stance  = (o_phase == PH_LOAD) || (o_phase == PH_MID)
                       || (o_phase == PH_TSTANCE) || (o_phase == PH_PRESWING);

endmodule
